>>> hw/rtl/etd_pkg.sv
// Package: shared constants and types of the event timer dispatcher.
`timescale 1ns / 1ps
package etd_pkg;
  localparam int unsigned NumSlots  = 16;
  localparam int unsigned NumLevels = 32;
  localparam logic [4:0]  AppLevel  = 5'd4;
  localparam int unsigned SlotW     = 4;

  localparam logic [3:0] ModeCreate  = 4'd0;
  localparam logic [3:0] ModeClose   = 4'd1;
  localparam logic [3:0] ModeSignal  = 4'd2;
  localparam logic [3:0] ModeCheck   = 4'd3;
  localparam logic [3:0] ModeWait    = 4'd4;
  localparam logic [3:0] ModeTimer   = 4'd5;
  localparam logic [3:0] ModeRaise   = 4'd6;
  localparam logic [3:0] ModeRestore = 4'd7;
  localparam logic [3:0] ModeDisp    = 4'd8;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StInvalid  = 3'd1;
  localparam logic [2:0] StNoSlot   = 3'd2;
  localparam logic [2:0] StNotReady = 3'd3;
  localparam logic [2:0] StUnsup    = 3'd4;

  localparam int unsigned FlTimer = 0;
  localparam int unsigned FlNsig  = 1;
  localparam int unsigned FlNwait = 2;

  localparam logic [1:0] TkCancel  = 2'd0;
  localparam logic [1:0] TkPeriod  = 2'd2;
  localparam logic [1:0] TkInvalid = 2'd3;

  typedef struct packed {
    logic [3:0]  mode;
    logic [3:0]  slot;
    logic [2:0]  event_flags;
    logic        has_handler;
    logic [4:0]  level;
    logic [1:0]  timer_kind;
    logic [63:0] trigger_time;
    logic [63:0] time_now;
    logic [15:0] wait_mask;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] result_slot;
    logic [2:0] status;
    logic [4:0] value;
    logic       last;
  } res_t;
endpackage

>>> hw/rtl/etd_if.sv
// Interfaces: valid/ready channels for command and result words.
`timescale 1ns / 1ps
interface etd_cmd_if;
  logic          valid;
  logic          ready;
  etd_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface etd_res_if;
  logic          valid;
  logic          ready;
  etd_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/etd_ram.sv
// Generic RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
module etd_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and read one entry a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hw/rtl/etd_alu.sv
// Shared 64-bit unit: one add and one unsigned compare.
`timescale 1ns / 1ps
module etd_alu (
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] sum_o,
  output logic        ge_o
);
  // One wide add and one wide compare
  assign sum_o = a_i + b_i;
  assign ge_o  = (a_i >= b_i);
endmodule

>>> hw/rtl/event_timer_dispatcher.sv
// Top level: event and timer service sequencer over a 16-slot table.
//
// Use: one command word enters on cmd (valid/ready), and the block returns
// zero or more notify words followed by one status word (last = 1) on res.
// A command is taken only while the sequencer is idle; cmd_ready is low
// for the whole command. Create and close pass through one set-up state to
// the status word, and unknown modes go straight to it. A command that
// dispatches walks the slots in order, per slot reading the due time and
// period from RAM, comparing, then notifying and advancing, plus a step
// for each timer that fires to add its period on the shared 64-bit
// adder/comparer. Set timer first takes two multiply steps, and a wait
// follows the walk with a scan of the masked slots.
// Each result word waits in one output register; while the receiver
// stalls, a state with a word to send holds until the word is taken.
// Reset clears the slot flags and levels at once, zeroes the due times in
// flip-flop valid bits, and sets the current level to the application
// level. Period entries are written before they are read (create clears).
`timescale 1ns / 1ps
module event_timer_dispatcher (
  input logic clk_i,
  input logic rst_ni,
  etd_cmd_if.sink   cmd,
  etd_res_if.source res
);
  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SMul   = 4'd1;
  localparam logic [3:0] SMul2  = 4'd2;
  localparam logic [3:0] SSet   = 4'd3;
  localparam logic [3:0] SDRd   = 4'd4;
  localparam logic [3:0] SDCmp  = 4'd5;
  localparam logic [3:0] SDNext = 4'd6;
  localparam logic [3:0] SPost  = 4'd7;
  localparam logic [3:0] SWait  = 4'd8;
  localparam logic [3:0] SFin   = 4'd9;
  localparam logic [3:0] SOut   = 4'd10;
  localparam logic [3:0] SDAdv  = 4'd11;

  localparam int unsigned N = etd_pkg::NumSlots;

  logic [3:0]   state_q, state_d, ret_q, ret_d;
  etd_pkg::cmd_t cmd_q;
  logic [N-1:0] open_q, sig_q, dvalid_q;
  logic [2:0]   flags_q [N];
  logic [4:0]   lvl_q [N];
  logic [4:0]   cur_q;
  logic [3:0]   idx_q;
  logic [63:0]  acc_q;
  logic [2:0]   st_q;
  logic [3:0]   rs_q;
  logic [4:0]   val_q;
  logic         ovalid_q;
  etd_pkg::res_t odata_q;

  // RAM ports
  logic         due_we, per_we;
  logic [3:0]   due_wa, per_wa, ram_ra;
  logic [63:0]  due_wd, per_wd, due_rd, per_rd;

  etd_ram #(.Width(64), .Depth(N)) u_due (
    .clk_i, .we_i(due_we), .waddr_i(due_wa), .wdata_i(due_wd),
    .raddr_i(ram_ra), .rdata_o(due_rd));
  etd_ram #(.Width(64), .Depth(N)) u_per (
    .clk_i, .we_i(per_we), .waddr_i(per_wa), .wdata_i(per_wd),
    .raddr_i(ram_ra), .rdata_o(per_rd));

  // Shared unit
  logic [63:0] alu_a, alu_b, alu_sum;
  logic        alu_ge;
  etd_alu u_alu (.a_i(alu_a), .b_i(alu_b), .sum_o(alu_sum), .ge_o(alu_ge));

  logic [63:0] due_eff;
  assign due_eff = dvalid_q[idx_q] ? due_rd : 64'd0;

  // Result register emptiness
  logic out_free;
  assign out_free = !ovalid_q || res.ready;

  assign cmd.ready = (state_q == SIdle);
  assign res.valid = ovalid_q;
  assign res.data  = odata_q;
  assign ram_ra    = idx_q;

  // Command decode helpers
  logic [3:0] s;
  logic [2:0] sfl;
  logic       fire, notify, nwait_ok;
  logic [N-1:0] free_vec;
  logic [3:0] free_idx;
  logic       free_any;
  assign s   = cmd_q.slot;
  assign sfl = flags_q[s];

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    free_vec = ~open_q;
    for (int i = N - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_any = 1'b1;
        free_idx = i[3:0];
      end
    end
  end

  assign fire = open_q[idx_q] && flags_q[idx_q][etd_pkg::FlTimer] &&
                (due_eff != 64'd0) && alu_ge;
  assign notify = sig_q[idx_q] && flags_q[idx_q][etd_pkg::FlNsig] &&
                  (cur_q <= lvl_q[idx_q]) && open_q[idx_q];
  assign nwait_ok = flags_q[idx_q][etd_pkg::FlNwait] && (cur_q <= lvl_q[idx_q]);

  // Sequencer
  logic [N-1:0] open_d, sig_d, dvalid_d;
  logic [2:0]   flags_d [N];
  logic [4:0]   lvl_d [N];
  logic [4:0]   cur_d;
  logic [3:0]   idx_d;
  logic [63:0]  acc_d;
  logic [2:0]   st_d;
  logic [3:0]   rs_d;
  logic [4:0]   val_d;
  logic         ovalid_d, emit;
  etd_pkg::res_t edata;

  always_comb begin
    state_d = state_q; ret_d = ret_q;
    open_d = open_q; sig_d = sig_q; dvalid_d = dvalid_q;
    flags_d = flags_q; lvl_d = lvl_q; cur_d = cur_q;
    idx_d = idx_q; acc_d = acc_q; st_d = st_q; rs_d = rs_q; val_d = val_q;
    due_we = 1'b0; due_wa = idx_q; due_wd = alu_sum;
    per_we = 1'b0; per_wa = s; per_wd = acc_q;
    alu_a = cmd_q.time_now; alu_b = due_eff;
    emit = 1'b0; edata = '0;
    ovalid_d = ovalid_q && !res.ready;

    case (state_q)
      SIdle: begin
        st_d = etd_pkg::StOk; rs_d = '0; val_d = '0; idx_d = '0;
        state_d = SFin;
        if (cmd.valid) begin
          case (cmd.data.mode)
            etd_pkg::ModeCreate, etd_pkg::ModeClose, etd_pkg::ModeSignal,
            etd_pkg::ModeCheck, etd_pkg::ModeWait, etd_pkg::ModeTimer,
            etd_pkg::ModeRaise, etd_pkg::ModeRestore, etd_pkg::ModeDisp:
              state_d = SSet;
            default: st_d = etd_pkg::StUnsup;
          endcase
        end else begin
          state_d = SIdle;
        end
      end
      SSet: begin
        state_d = SDRd; ret_d = SPost;
        case (cmd_q.mode)
          etd_pkg::ModeCreate: begin
            state_d = SFin;
            if (cmd_q.event_flags[etd_pkg::FlNsig] &&
                cmd_q.event_flags[etd_pkg::FlNwait]) begin
              st_d = etd_pkg::StInvalid;
            end else if ((cmd_q.event_flags[etd_pkg::FlNsig] ||
                          cmd_q.event_flags[etd_pkg::FlNwait]) &&
                         !cmd_q.has_handler) begin
              st_d = etd_pkg::StInvalid;
            end else if (!free_any) begin
              st_d = etd_pkg::StNoSlot;
            end else begin
              open_d[free_idx] = 1'b1; sig_d[free_idx] = 1'b0;
              flags_d[free_idx] = cmd_q.event_flags;
              lvl_d[free_idx] = cmd_q.level;
              dvalid_d[free_idx] = 1'b0;
              per_we = 1'b1; per_wa = free_idx; per_wd = '0;
              rs_d = free_idx;
            end
          end
          etd_pkg::ModeClose: begin
            state_d = SFin;
            open_d[s] = 1'b0; dvalid_d[s] = 1'b0; lvl_d[s] = '0;
          end
          etd_pkg::ModeSignal: begin
            if (open_q[s]) sig_d[s] = 1'b1;
          end
          etd_pkg::ModeCheck: begin
            if (sfl[etd_pkg::FlNsig]) begin
              st_d = etd_pkg::StInvalid; state_d = SFin;
            end
          end
          etd_pkg::ModeWait: begin
            if (cur_q != etd_pkg::AppLevel) begin
              st_d = etd_pkg::StUnsup; state_d = SFin;
            end else if (cmd_q.wait_mask == 16'd0) begin
              st_d = etd_pkg::StInvalid; state_d = SFin;
            end else begin
              st_d = etd_pkg::StNotReady;
            end
          end
          etd_pkg::ModeTimer: begin
            if (!open_q[s] || !sfl[etd_pkg::FlTimer] ||
                cmd_q.timer_kind == etd_pkg::TkInvalid) begin
              st_d = etd_pkg::StInvalid; state_d = SFin;
            end else if (cmd_q.timer_kind == etd_pkg::TkCancel) begin
              dvalid_d[s] = 1'b0;
            end else begin
              // x64 + x32 first
              alu_a = {cmd_q.trigger_time[57:0], 6'd0};
              alu_b = {cmd_q.trigger_time[58:0], 5'd0};
              acc_d = alu_sum; state_d = SMul;
            end
          end
          etd_pkg::ModeRaise: begin
            val_d = cur_q;
          end
          etd_pkg::ModeRestore: begin
            cur_d = cmd_q.level;
          end
          default: begin
            val_d = {4'd0, |open_q};
          end
        endcase
      end
      SMul: begin
        // add x4 to finish x100
        alu_a = acc_q; alu_b = {cmd_q.trigger_time[61:0], 2'b00};
        acc_d = alu_sum;
        per_we = 1'b1; per_wa = s;
        per_wd = (cmd_q.timer_kind == etd_pkg::TkPeriod) ? alu_sum : 64'd0;
        state_d = SMul2;
      end
      SMul2: begin
        alu_a = cmd_q.time_now; alu_b = acc_q;
        due_we = 1'b1; due_wa = s; due_wd = alu_sum;
        dvalid_d[s] = 1'b1;
        state_d = SDRd;
      end
      SDRd: begin
        state_d = SDCmp;
      end
      SDCmp: begin
        // fire a due timer for the slot under idx
        if (fire) begin
          sig_d[idx_q] = 1'b1;
          state_d = SDAdv;
        end else begin
          state_d = SDNext;
        end
      end
      SDAdv: begin
        // advance a periodic timer, retire a one-shot
        alu_a = due_eff; alu_b = per_rd;
        due_we = 1'b1; due_wa = idx_q;
        due_wd = (per_rd != 64'd0) ? alu_sum : 64'd0;
        state_d = SDNext;
      end
      SDNext: begin
        // notify a signaled slot, then move to the next slot
        if (notify && !out_free) begin
          state_d = SDNext;
        end else begin
          if (notify) begin
            sig_d[idx_q] = 1'b0;
            emit = 1'b1; edata.result_slot = idx_q;
          end
          idx_d = idx_q + 4'd1;
          state_d = (idx_q == 4'(N - 1)) ? ret_q : SDRd;
        end
      end
      SPost: begin
        state_d = SFin; idx_d = '0;
        case (cmd_q.mode)
          etd_pkg::ModeCheck: begin
            if (sig_q[s]) begin
              sig_d[s] = 1'b0;
            end else begin
              st_d = etd_pkg::StNotReady;
              if (sfl[etd_pkg::FlNwait] && cur_q <= lvl_q[s]) begin
                if (out_free) begin
                  emit = 1'b1; edata.result_slot = s;
                end else begin
                  state_d = SPost;
                end
              end
            end
          end
          etd_pkg::ModeWait: state_d = SWait;
          etd_pkg::ModeRaise: begin
            if (cmd_q.level >= cur_q) cur_d = cmd_q.level;
          end
          default: ;
        endcase
      end
      SWait: begin
        // scan masked open slots one a cycle, holding while a notify word waits
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'(N - 1)) state_d = SFin;
        if (cmd_q.wait_mask[idx_q] && open_q[idx_q]) begin
          if (flags_q[idx_q][etd_pkg::FlNsig]) begin
            st_d = etd_pkg::StInvalid; rs_d = idx_q; state_d = SFin;
          end else if (sig_q[idx_q]) begin
            sig_d[idx_q] = 1'b0; st_d = etd_pkg::StOk; rs_d = idx_q;
            state_d = SFin;
          end else if (nwait_ok) begin
            if (out_free) begin
              emit = 1'b1; edata.result_slot = idx_q;
            end else begin
              idx_d = idx_q; state_d = SWait;
            end
          end
        end
      end
      SFin: begin
        if (out_free) begin
          emit = 1'b1;
          edata.kind = 1'b1; edata.result_slot = rs_q;
          edata.status = st_q; edata.value = val_q; edata.last = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
    if (emit) ovalid_d = 1'b1;
  end

  // State and table registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; ret_q <= SPost;
      open_q <= '0; sig_q <= '0; dvalid_q <= '0;
      for (int i = 0; i < N; i++) begin
        flags_q[i] <= '0; lvl_q[i] <= '0;
      end
      cur_q <= etd_pkg::AppLevel; ovalid_q <= 1'b0; idx_q <= '0;
    end else begin
      state_q <= state_d; ret_q <= ret_d;
      open_q <= open_d; sig_q <= sig_d; dvalid_q <= dvalid_d;
      flags_q <= flags_d; lvl_q <= lvl_d;
      cur_q <= cur_d; ovalid_q <= ovalid_d; idx_q <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd.valid && cmd.ready) cmd_q <= cmd.data;
    acc_q <= acc_d; st_q <= st_d; rs_q <= rs_d; val_q <= val_d;
    if (emit) odata_q <= edata;
  end

  // Commands are taken only when idle
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ready |-> state_q == SIdle) else $error("ready outside idle");
  // A stalled word is not overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !res.ready |=> res.valid && $stable(res.data))
    else $error("result word lost");
  // Status word always returns to idle
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SFin && out_free |=> state_q == SIdle && res.data.last)
    else $error("final word missing");
endmodule
